// ===== sv/qrs_pkg.sv =====
package qrs_pkg;

   localparam int COUNT_BITS     = 16;
   localparam int POSITION_BITS  = 32;
   localparam int THRESHOLD_BITS = 24;
   localparam int INPUT_BITS     = 24;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 24;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX           = '1;
   localparam logic [COUNT_BITS-1:0] REFRACTORY_RESET    = 16'd16;
   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = '0;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_REFRACTORY_LIMIT  = 4'd0,
      CSR_INITIAL_THRESHOLD = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic                      beat_found;
      logic [COUNT_BITS-1:0]     beat_interval;
      logic [POSITION_BITS-1:0]  beat_position;
      logic [THRESHOLD_BITS-1:0] current_threshold;
   } result_type;

endpackage

// ===== sv/qrs_step.sv =====
module qrs_step #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   step,
   input  logic [SAMPLE_BITS-1:0]                 sample,
   input  logic                                   csr_write,
   input  logic [qrs_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [qrs_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   output qrs_pkg::result_type                    result
);
   import qrs_pkg::*;

   logic [COUNT_BITS-1:0]    refractory_ff, refractory_in;
   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic [SAMPLE_BITS-1:0]   peak_ff, peak_in;
   logic [SAMPLE_BITS-1:0]   thr_ff, thr_in;
   logic [POSITION_BITS-1:0] position_ff, position_in;

   logic [COUNT_BITS-1:0]    count_inc;
   logic                     armed;
   logic                     beat;
   logic [SAMPLE_BITS+2:0]   thr_sum;
   logic [SAMPLE_BITS-1:0]   thr_next;
   logic [POSITION_BITS-1:0] position_next;

   assign count_inc = (count_ff != COUNT_MAX) ? count_ff + 1'b1 : count_ff;
   assign armed     = (count_inc > refractory_ff) && (sample > thr_ff);
   assign beat      = armed && (sample < peak_ff);

   // peak/8 + 7/8 threshold: 7*thr written as 8*thr - thr
   assign thr_sum  = {3'b000, peak_ff} + {thr_ff, 3'b000} - {3'b000, thr_ff};
   assign thr_next = thr_sum[SAMPLE_BITS+2:3];
   assign position_next = position_ff + POSITION_BITS'(count_inc);

   always_comb begin
      refractory_in = refractory_ff;
      count_in      = count_ff;
      peak_in       = peak_ff;
      thr_in        = thr_ff;
      position_in   = position_ff;
      if (step) begin
         count_in = count_inc;
         if (beat) begin
            count_in    = '0;
            peak_in     = '0;
            thr_in      = thr_next;
            position_in = position_next;
         end else if (armed && (sample > peak_ff)) begin
            peak_in = sample;
         end
      end
      if (csr_write) begin
         if (csr_index == CSR_REFRACTORY_LIMIT) begin
            refractory_in = csr_wdata[COUNT_BITS-1:0];
         end else if (csr_index == CSR_INITIAL_THRESHOLD) begin
            thr_in = SAMPLE_BITS'(csr_wdata[THRESHOLD_BITS-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         refractory_ff <= REFRACTORY_RESET;
         count_ff      <= '0;
         peak_ff       <= '0;
         thr_ff        <= SAMPLE_BITS'(THRESHOLD_RESET);
         position_ff   <= '0;
      end else begin
         refractory_ff <= refractory_in;
         count_ff      <= count_in;
         peak_ff       <= peak_in;
         thr_ff        <= thr_in;
         position_ff   <= position_in;
      end
   end

   always_comb begin
      result.beat_found        = beat;
      result.beat_interval     = beat ? count_inc : '0;
      result.beat_position     = beat ? position_next : position_ff;
      result.current_threshold = beat ? THRESHOLD_BITS'(thr_next) : THRESHOLD_BITS'(thr_ff);
   end

   a_beat_clears: assert property (@(posedge clock) disable iff (reset)
      step && beat && !csr_write |=> (count_ff == '0) && (peak_ff == '0))
      else $error("count or peak not cleared after beat");

   a_position_advance: assert property (@(posedge clock) disable iff (reset)
      step && beat |=> position_ff == $past(position_ff) + POSITION_BITS'($past(count_inc)))
      else $error("beat position did not advance by the interval");

   a_thr_hold: assert property (@(posedge clock) disable iff (reset)
      !step && !csr_write |=> $stable(thr_ff) && $stable(count_ff) && $stable(peak_ff))
      else $error("detector state moved without a request");

   a_peak_above_thr: assert property (@(posedge clock) disable iff (reset)
      step && armed && (sample > peak_ff) && !csr_write |=> peak_ff > thr_ff)
      else $error("tracked peak not above threshold");

endmodule

// ===== sv/qrs_peak_detector.sv =====
// channel | handshake            | payload
// req     | req_valid, req_stall | req_sample
// rsp     | rsp_valid, rsp_stall | rsp_beat_found/_interval/_position, rsp_current_threshold
// csr     | csr_write            | csr_index, csr_wdata (no read-back)
//
// A request passes through an input register, then the step logic into the result register.
// One request per cycle sustained while rsp_stall is low; the detector state updates as a
// request leaves the input register. Synchronous reset clears both registers' valid bits and
// the state. rsp_stall holds the result register and, once the input register is full, req_stall.
module qrs_peak_detector #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [qrs_pkg::INPUT_BITS-1:0]            req_sample,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic                                      rsp_beat_found,
   output logic [qrs_pkg::COUNT_BITS-1:0]            rsp_beat_interval,
   output logic [qrs_pkg::POSITION_BITS-1:0]         rsp_beat_position,
   output logic [qrs_pkg::THRESHOLD_BITS-1:0]        rsp_current_threshold,
   input  logic                                      csr_write,
   input  logic [qrs_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [qrs_pkg::CSR_DATA_BITS-1:0]         csr_wdata
);
   import qrs_pkg::*;

   logic                   in_valid_ff, in_valid_in;
   logic [SAMPLE_BITS-1:0] in_sample_ff, in_sample_in;
   logic                   out_valid_ff, out_valid_in;
   result_type             out_ff, out_in;
   result_type             step_result;
   logic                   out_open;
   logic                   advance;
   logic                   req_take;

   assign out_open  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_open;
   assign req_stall = in_valid_ff && !out_open;
   assign req_take  = req_valid && !req_stall;

   qrs_step #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_step (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .sample    (in_sample_ff),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .result    (step_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_sample_in = in_sample_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in  = 1'b1;
         in_sample_in = SAMPLE_BITS'(req_sample);
      end
      if (out_open) begin
         out_valid_in = advance;
         out_in       = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_sample_ff <= in_sample_in;
      out_ff       <= out_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_beat_found        = out_ff.beat_found;
   assign rsp_beat_interval     = out_ff.beat_interval;
   assign rsp_beat_position     = out_ff.beat_position;
   assign rsp_current_threshold = out_ff.current_threshold;

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_sample_ff))
      else $error("held request lost from input register");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("stepped request produced no result");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      out_open && !advance |=> !out_valid_ff)
      else $error("result appeared without a request");

endmodule
